/* design/pcrs_pkg.sv */
// Package: shared constants, types and command/status structs for running statistics.
`default_nettype none
package pcrs_pkg;
  localparam int unsigned CapacityDef = 256;
  localparam int unsigned ChannelsDef = 4;
  localparam int unsigned ChanW = 2;
  localparam int unsigned ScoreW = 8;
  localparam int unsigned MeanW = 16;
  localparam int unsigned SdW = 15;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SHIFT_RD,
    ST_SHIFT_CMP,
    ST_WRITE,
    ST_MED_RD,
    ST_MED_WAIT,
    ST_DIV,
    ST_SQRT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic rd_prev;
    logic move_down;
    logic write_val;
    logic commit;
    logic med_rd;
    logic med_take;
    logic div_start;
    logic div_step;
    logic sqrt_start;
    logic sqrt_step;
  } cmd_t;

  typedef struct packed {
    logic valid_ch;
    logic full;
    logic empty;
    logic pos_zero;
    logic prev_gt;
    logic div_done;
    logic sqrt_done;
  } status_t;
endpackage
`default_nettype wire

/* design/pcrs_if.sv */
// Interfaces: valid/ready channels for score beats and statistics beats.
`default_nettype none
interface pcrs_in_if import pcrs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ChanW-1:0]  channel;
  logic [ScoreW-1:0] score;
  modport source (output valid, channel, score, input ready);
  modport sink (input valid, channel, score, output ready);
endinterface

interface pcrs_out_if import pcrs_pkg::*; #(parameter int unsigned CountW = 9) ();
  logic              valid;
  logic              ready;
  logic              accepted;
  logic [CountW-1:0] sample_count;
  logic [MeanW-1:0]  mean_q8;
  logic [ScoreW-1:0] median_value;
  logic [SdW-1:0]    std_dev_q8;
  modport source (output valid, accepted, sample_count, mean_q8, median_value, std_dev_q8,
                  input ready);
  modport sink (input valid, accepted, sample_count, mean_q8, median_value, std_dev_q8,
                output ready);
endinterface
`default_nettype wire

/* design/per_channel_running_statistics.sv */
// Top level: per-channel running mean, median and standard deviation.
// Each score beat is inserted in order into its channel's store by walking down from the
// end, one entry at a time (read, then compare and move): insertion walk, then a
// one-bit-per-cycle divider over NumW bits, with NumW = 2*CountW + 32, and a
// two-bits-per-cycle square root. A full channel skips the walk. One beat at a time.
`default_nettype none
module per_channel_running_statistics import pcrs_pkg::*; #(
  parameter int unsigned Capacity = CapacityDef,
  parameter int unsigned Channels = ChannelsDef,
  localparam int unsigned CountW = $clog2(Capacity + 1)
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  pcrs_in_if.sink  in_i,
  pcrs_out_if.source out_o
);
  cmd_t    cmd;
  status_t status;
  logic              acc_w;
  logic [CountW-1:0] cnt_w;
  logic [MeanW-1:0]  mean_w;
  logic [ScoreW-1:0] med_w;
  logic [SdW-1:0]    sd_w;

  pcrs_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pcrs_datapath #(.Capacity(Capacity), .Channels(Channels)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i         (cmd),
    .status_o      (status),
    .channel_i     (in_i.channel),
    .score_i       (in_i.score),
    .accepted_o    (acc_w),
    .sample_count_o(cnt_w),
    .mean_q8_o     (mean_w),
    .median_value_o(med_w),
    .std_dev_q8_o  (sd_w)
  );

  logic              acc_q;
  logic [CountW-1:0] cnt_q;
  logic [MeanW-1:0]  mean_q;
  logic [ScoreW-1:0] med_q;
  logic [SdW-1:0]    sd_q;
  always_ff @(posedge clk_i) begin
    if (!out_o.valid || out_o.ready) begin
      acc_q  <= acc_w;
      cnt_q  <= cnt_w;
      mean_q <= mean_w;
      med_q  <= med_w;
      sd_q   <= sd_w;
    end
  end
  assign out_o.accepted     = acc_q;
  assign out_o.sample_count = cnt_q;
  assign out_o.mean_q8      = mean_q;
  assign out_o.median_value = med_q;
  assign out_o.std_dev_q8   = sd_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready) else $error("input taken while busy");
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.move_down && cmd.write_val)) else $error("store write conflict");
  a_commit_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> !status.full) else $error("commit on full channel");
endmodule
`default_nettype wire

/* design/pcrs_ctrl.sv */
// Controller: sequences insertion, median fetch, division and square root.
`default_nettype none
module pcrs_ctrl import pcrs_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);
  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!status_i.valid_ch || status_i.empty) state_d = ST_OUT;
        else if (status_i.full) state_d = ST_MED_RD;
        else if (status_i.pos_zero) state_d = ST_WRITE;
        else begin
          cmd_o.rd_prev = 1'b1;
          state_d       = ST_SHIFT_RD;
        end
      end
      ST_SHIFT_RD: state_d = ST_SHIFT_CMP;
      ST_SHIFT_CMP: begin
        if (status_i.prev_gt) begin
          cmd_o.move_down = 1'b1;
          if (status_i.pos_zero) state_d = ST_WRITE;
          else begin
            cmd_o.rd_prev = 1'b1;
            state_d       = ST_SHIFT_RD;
          end
        end else begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd_o.write_val = 1'b1;
        cmd_o.commit    = 1'b1;
        state_d         = ST_MED_RD;
      end
      ST_MED_RD: begin
        cmd_o.med_rd = 1'b1;
        state_d      = ST_MED_WAIT;
      end
      ST_MED_WAIT: begin
        cmd_o.med_take  = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          cmd_o.sqrt_start = 1'b1;
          state_d          = ST_SQRT;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_SQRT: begin
        if (status_i.sqrt_done) state_d = ST_OUT;
        else cmd_o.sqrt_step = 1'b1;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

/* design/pcrs_datapath.sv */
// Datapath: per-channel store, accumulators, shared divider and square root.
`default_nettype none
module pcrs_datapath import pcrs_pkg::*; #(
  parameter int unsigned Capacity = CapacityDef,
  parameter int unsigned Channels = ChannelsDef,
  localparam int unsigned CountW = $clog2(Capacity + 1),
  localparam int unsigned PosW = $clog2(Capacity),
  localparam int unsigned SumW = CountW + ScoreW,
  localparam int unsigned SqW = CountW + 2 * ScoreW,
  localparam int unsigned NumW = CountW + SqW + 16,
  localparam int unsigned DenW = 2 * CountW,
  localparam int unsigned QW = NumW,
  localparam int unsigned RootW = (QW + 1) / 2,
  localparam int unsigned DivCntW = $clog2(NumW + 1),
  localparam int unsigned SqCntW = $clog2(RootW + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cmd_t              cmd_i,
  output status_t                status_o,
  input  wire logic [ChanW-1:0]  channel_i,
  input  wire logic [ScoreW-1:0] score_i,
  output logic                   accepted_o,
  output logic [CountW-1:0]      sample_count_o,
  output logic [MeanW-1:0]       mean_q8_o,
  output logic [ScoreW-1:0]      median_value_o,
  output logic [SdW-1:0]         std_dev_q8_o
);
  localparam int unsigned ChIdxW = (Channels > 1) ? $clog2(Channels) : 1;
  localparam int unsigned AddrW = ChIdxW + PosW;

  logic [ScoreW-1:0] mem_q [Channels << PosW];
  logic [ScoreW-1:0] rd_q;
  logic [CountW-1:0] cnt_q [Channels];
  logic [SumW-1:0]   sum_q [Channels];
  logic [SqW-1:0]    sq_q  [Channels];

  logic [ChIdxW-1:0] ch_q;
  logic              chv_q;
  logic [ScoreW-1:0] val_q;
  logic [CountW-1:0] pos_q;
  logic [CountW-1:0] n_q;
  logic              acc_q;
  logic [SumW-1:0]   s_q;
  logic [SqW-1:0]    sq2_q;
  logic [ScoreW-1:0] med_q;

  logic [NumW-1:0]   drem_q, dquo_q;
  logic [DenW-1:0]   dden_q;
  logic [DivCntW-1:0] dcnt_q;
  logic [SumW+8-1:0] mrem_q, mquo_q;
  logic [QW-1:0]     sv_q;
  logic [RootW-1:0]  sr_q;
  logic [RootW+1:0]  srem_q;
  logic [SqCntW-1:0] scnt_q;

  logic              ch_ok;
  logic [ChIdxW-1:0] ch_idx;
  logic [CountW-1:0] cur_cnt;
  logic [CountW-1:0] n_new;
  logic [AddrW-1:0]  addr_prev, addr_pos, addr_med;

  assign ch_ok   = ({{(32-ChanW){1'b0}}, channel_i} < Channels);
  assign ch_idx  = ChIdxW'(channel_i);
  assign cur_cnt = cnt_q[ch_idx];
  assign n_new   = n_q;
  assign addr_prev = cmd_i.move_down ? {ch_q, PosW'(pos_q - 2'd2)}
                                     : {ch_q, PosW'(pos_q - 1'b1)};
  assign addr_pos  = {ch_q, pos_q[PosW-1:0]};
  assign addr_med  = {ch_q, PosW'(n_q >> 1)};

  assign status_o.valid_ch  = chv_q;
  assign status_o.full      = !acc_q;
  assign status_o.empty     = (n_q == '0);
  assign status_o.pos_zero  = cmd_i.move_down ? (pos_q == CountW'(1)) : (pos_q == '0);
  assign status_o.prev_gt   = rd_q > val_q;
  assign status_o.div_done  = (dcnt_q == '0);
  assign status_o.sqrt_done = (scnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_prev) rd_q <= mem_q[addr_prev];
    else if (cmd_i.med_rd) rd_q <= mem_q[addr_med];
    if (cmd_i.move_down) mem_q[addr_pos] <= rd_q;
    else if (cmd_i.write_val) mem_q[addr_pos] <= val_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Channels; i++) begin
        cnt_q[i] <= '0;
        sum_q[i] <= '0;
        sq_q[i]  <= '0;
      end
    end else if (cmd_i.commit) begin
      cnt_q[ch_q] <= n_q;
      sum_q[ch_q] <= s_q;
      sq_q[ch_q]  <= sq2_q;
    end
  end

  // Item registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ch_q  <= ch_idx;
      chv_q <= ch_ok;
      val_q <= score_i;
      pos_q <= cur_cnt;
      med_q <= '0;
      if (ch_ok && cur_cnt < CountW'(Capacity)) begin
        acc_q <= 1'b1;
        n_q   <= cur_cnt + 1'b1;
        s_q   <= sum_q[ch_idx] + SumW'(score_i);
        sq2_q <= sq_q[ch_idx] + SqW'(score_i) * SqW'(score_i);
      end else begin
        acc_q <= 1'b0;
        n_q   <= ch_ok ? cur_cnt : '0;
        s_q   <= sum_q[ch_idx];
        sq2_q <= sq_q[ch_idx];
      end
    end else if (cmd_i.move_down) begin
      pos_q <= pos_q - 1'b1;
    end
    if (cmd_i.med_take) med_q <= rd_q;
  end

  // Restoring dividers, one quotient bit per cycle
  logic [NumW-1:0]   num_full;
  logic [NumW:0]     dtrial;
  logic [SumW+8:0]   mtrial;
  assign num_full = (NumW'(n_q) * NumW'(sq2_q) - NumW'(s_q) * NumW'(s_q)) << 16;
  assign dtrial = {drem_q, dquo_q[NumW-1]} - {{(NumW+1-DenW){1'b0}}, dden_q};
  assign mtrial = {mrem_q, mquo_q[SumW+7]} - (SumW+9)'(n_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      drem_q <= '0;
      dquo_q <= num_full;
      dden_q <= DenW'(n_q) * DenW'(n_q);
      mrem_q <= '0;
      mquo_q <= {s_q, 8'd0};
      dcnt_q <= DivCntW'(NumW);
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q - 1'b1;
      if (!dtrial[NumW]) begin
        drem_q <= dtrial[NumW-1:0];
        dquo_q <= {dquo_q[NumW-2:0], 1'b1};
      end else begin
        drem_q <= {drem_q[NumW-2:0], dquo_q[NumW-1]};
        dquo_q <= {dquo_q[NumW-2:0], 1'b0};
      end
      if (dcnt_q <= DivCntW'(SumW + 8)) begin
        if (!mtrial[SumW+8]) begin
          mrem_q <= mtrial[SumW+7:0];
          mquo_q <= {mquo_q[SumW+6:0], 1'b1};
        end else begin
          mrem_q <= {mrem_q[SumW+6:0], mquo_q[SumW+7]};
          mquo_q <= {mquo_q[SumW+6:0], 1'b0};
        end
      end
    end
  end

  // Digit-by-digit square root, two radicand bits per cycle
  logic [RootW+1:0] strial;
  logic [RootW+1:0] srem_sh;
  assign srem_sh = {srem_q[RootW-1:0], sv_q[QW-1 -: 2]};
  assign strial  = srem_sh - {sr_q, 2'b01};

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      sv_q   <= dquo_q;
      sr_q   <= '0;
      srem_q <= '0;
      scnt_q <= SqCntW'(RootW);
    end else if (cmd_i.sqrt_step) begin
      scnt_q <= scnt_q - 1'b1;
      sv_q   <= sv_q << 2;
      if (!strial[RootW+1]) begin
        srem_q <= strial;
        sr_q   <= {sr_q[RootW-2:0], 1'b1};
      end else begin
        srem_q <= srem_sh;
        sr_q   <= {sr_q[RootW-2:0], 1'b0};
      end
    end
  end

  assign accepted_o     = acc_q;
  assign sample_count_o = n_new;
  assign mean_q8_o      = (n_q == '0) ? '0 : MeanW'(mquo_q);
  assign median_value_o = med_q;
  assign std_dev_q8_o   = (n_q == '0) ? '0 : SdW'(sr_q);
endmodule
`default_nettype wire

/* verif/tb_top.sv */
// Testbench for per_channel_running_statistics: queued score beats, predicted stats, compare.
`default_nettype none
module tb_top;
  import pcrs_pkg::*;

  typedef struct packed {
    logic [ChanW-1:0]  channel;
    logic [ScoreW-1:0] score;
  } score_beat_t;

  typedef struct packed {
    logic              accepted;
    logic [8:0]        sample_count;
    logic [MeanW-1:0]  mean_q8;
    logic [ScoreW-1:0] median_value;
    logic [SdW-1:0]    std_dev_q8;
  } stats_t;

  localparam int unsigned Cap = CapacityDef;
  localparam int unsigned Chans = ChannelsDef;
  localparam longint unsigned CycleLimit = 6000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pcrs_in_if in_bus ();
  pcrs_out_if #(.CountW(9)) out_bus ();

  per_channel_running_statistics uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus.sink),
    .out_o (out_bus.source)
  );

  always #5 clk_i = ~clk_i;

  score_beat_t pending_beats[$];
  stats_t      expected_stats[$];
  int          sorted_store[Chans][$];
  longint unsigned ch_count[Chans];
  longint unsigned ch_sum[Chans];
  longint unsigned ch_sumsq[Chans];
  bit          failed = 1'b0;
  bit          stim_done = 1'b0;
  bit          calm = 1'b0;
  bit          in_taken = 1'b0;
  longint unsigned cycles = 0;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic stats_t predict_stats(score_beat_t b);
    stats_t r;
    int ch, pos;
    longint unsigned n, s, sq, num;
    r = '0;
    ch = b.channel;
    if (ch < Chans) begin
      if (ch_count[ch] < Cap) begin
        pos = sorted_store[ch].size();
        while (pos > 0 && sorted_store[ch][pos-1] > b.score) pos--;
        sorted_store[ch].insert(pos, b.score);
        ch_count[ch]++;
        ch_sum[ch] += b.score;
        ch_sumsq[ch] += b.score * b.score;
        r.accepted = 1'b1;
      end
      n = ch_count[ch];
      r.sample_count = n[8:0];
      if (n > 0) begin
        s = ch_sum[ch];
        sq = ch_sumsq[ch];
        num = n * sq - s * s;
        r.mean_q8 = MeanW'((s << 8) / n);
        r.median_value = ScoreW'(sorted_store[ch][n / 2]);
        r.std_dev_q8 = SdW'(isqrt((num << 16) / (n * n)));
      end
    end
    return r;
  endfunction

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 38);
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_bus.valid && !in_taken) begin
      end else if (pending_beats.size() > 0 && !idle_now()) begin
        in_bus.valid <= 1'b1;
        {in_bus.channel, in_bus.score} <= pending_beats.pop_front();
      end else begin
        in_bus.valid <= 1'b0;
      end
      out_bus.ready <= !idle_now();
    end
  end

  // accepted inputs feed the predictor; results are checked
  always @(posedge clk_i) begin
    stats_t got, want;
    in_taken = rst_ni && in_bus.valid && in_bus.ready;
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready)
        expected_stats.insert(expected_stats.size(),
                              predict_stats({in_bus.channel, in_bus.score}));
      if (out_bus.valid && out_bus.ready) begin
        got = {out_bus.accepted, out_bus.sample_count, out_bus.mean_q8,
               out_bus.median_value, out_bus.std_dev_q8};
        if (expected_stats.size() == 0) begin
          $display("%0t: unexpected beat, actual %h", $time, got);
          failed = 1'b1;
        end else begin
          want = expected_stats.pop_front();
          if (got.accepted !== want.accepted) begin
            $display("%0t: accepted exp %0d act %0d", $time, want.accepted, got.accepted);
            failed = 1'b1;
          end
          if (got.sample_count !== want.sample_count) begin
            $display("%0t: sample_count exp %0d act %0d", $time, want.sample_count,
                     got.sample_count);
            failed = 1'b1;
          end
          if (got.mean_q8 !== want.mean_q8) begin
            $display("%0t: mean_q8 exp %0d act %0d", $time, want.mean_q8, got.mean_q8);
            failed = 1'b1;
          end
          if (got.median_value !== want.median_value) begin
            $display("%0t: median_value exp %0d act %0d", $time, want.median_value,
                     got.median_value);
            failed = 1'b1;
          end
          if (got.std_dev_q8 !== want.std_dev_q8) begin
            $display("%0t: std_dev_q8 exp %0d act %0d", $time, want.std_dev_q8,
                     got.std_dev_q8);
            failed = 1'b1;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic add_beat(int ch, int sc);
    score_beat_t b;
    b.channel = ch[ChanW-1:0];
    b.score = sc[ScoreW-1:0];
    pending_beats.insert(pending_beats.size(), b);
  endtask

  initial begin
    int mode;
    in_bus.valid = 1'b0;
    in_bus.channel = '0;
    in_bus.score = '0;
    out_bus.ready = 1'b0;
    // directed: extremes, each channel, ties, descending order
    add_beat(0, 0);
    add_beat(0, 255);
    add_beat(0, 255);
    add_beat(0, 0);
    add_beat(1, 255);
    add_beat(1, 128);
    add_beat(1, 1);
    add_beat(2, 170);
    add_beat(2, 85);
    add_beat(2, 170);
    add_beat(3, 127);
    add_beat(3, 200);
    add_beat(3, 50);
    add_beat(3, 254);
    // random: channel 3 is filled past capacity to exercise the full case
    for (int i = 0; i < 1450; i++) begin
      if (i < 300) add_beat(3, $urandom_range(255));
      else begin
        mode = $urandom_range(9);
        if (mode < 2) add_beat($urandom_range(3), $urandom_range(1) ? 0 : 255);
        else if (mode < 4) add_beat($urandom_range(2), $urandom_range(120, 135));
        else add_beat($urandom_range(3), $urandom_range(255));
      end
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (pending_beats.size() < 700);
    calm = 1'b1;
    wait (pending_beats.size() < 500);
    calm = 1'b0;
    wait (pending_beats.size() == 0);
    @(posedge clk_i);
    wait (!in_bus.valid);
    @(posedge clk_i);
    wait (expected_stats.size() == 0);
    repeat (700) @(posedge clk_i);
    if (!failed && expected_stats.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
